### rtl/core/fah_pkg.sv
// Shared types, constants and the FNV-1a mixing function for the accession hasher.
package fah_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  typedef enum logic [1:0] {
    PH_LINE_START = 2'd0,
    PH_BLANKS     = 2'd1,
    PH_TOKEN      = 2'd2,
    PH_SKIP_LINE  = 2'd3
  } fah_phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_data;
  } fah_word_t;

  typedef struct packed {
    logic        emit;
    logic [63:0] hash;
  } fah_result_t;

  // xor in the byte, then multiply by the prime 2^40 + 0x1B3 as shifts and adds
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] c);
    logic [63:0] x;
    x = h ^ {56'd0, c};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### rtl/core/fah_in_stage.sv
// Input register: holds one accepted text word until the parser takes it.
module fah_in_stage
  import fah_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fah_word_t in_word,
  input  logic      advance,
  output logic      word_valid,
  output fah_word_t word
);

  logic      valid_r, valid_nxt;
  fah_word_t word_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !advance);
  assign word_valid = valid_r;
  assign word       = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

### rtl/core/fah_parser.sv
// Header parser and running FNV-1a hash; one text word per step.
module fah_parser
  import fah_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  fah_word_t   word,
  output fah_result_t result
);

  fah_phase_t  phase_r, phase_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] mixed;
  logic [7:0]  c;
  logic        blank, lf, cr;

  assign c     = word.text_byte;
  assign blank = c inside {CH_SP, CH_TAB};
  assign lf    = (c == CH_LF);
  assign cr    = (c == CH_CR);
  // first token byte mixes into the basis, later bytes into the running hash
  assign mixed = fnv_mix((phase_r == PH_BLANKS) ? FNV_BASIS : hash_r, c);

  always_comb begin
    phase_nxt   = phase_r;
    hash_nxt    = hash_r;
    result.emit = 1'b0;
    result.hash = hash_r;
    case (phase_r)
      PH_BLANKS: begin
        if (blank) begin
          phase_nxt = PH_BLANKS;
        end else if (lf) begin
          phase_nxt = PH_LINE_START;
        end else if (cr) begin
          phase_nxt = PH_SKIP_LINE;
        end else begin
          hash_nxt  = mixed;
          phase_nxt = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (blank || cr || lf) begin
          result.emit = 1'b1;
          hash_nxt    = FNV_BASIS;
          phase_nxt   = lf ? PH_LINE_START : PH_SKIP_LINE;
        end else begin
          hash_nxt = mixed;
        end
      end
      PH_SKIP_LINE: begin
        if (lf) begin
          phase_nxt = PH_LINE_START;
        end
      end
      default: begin
        if (c == CH_GT) begin
          phase_nxt = PH_BLANKS;
        end else if (lf) begin
          phase_nxt = PH_LINE_START;
        end else begin
          phase_nxt = PH_SKIP_LINE;
        end
      end
    endcase
    // end of data: flush an open token, then return to line start
    if (word.end_of_data) begin
      if (phase_nxt == PH_TOKEN && !result.emit) begin
        result.emit = 1'b1;
        result.hash = hash_nxt;
      end
      phase_nxt = PH_LINE_START;
      hash_nxt  = FNV_BASIS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE_START;
      hash_r  <= FNV_BASIS;
    end else if (step) begin
      phase_r <= phase_nxt;
      hash_r  <= hash_nxt;
    end
  end

endmodule

### rtl/core/fah_out_stage.sv
// Result register: holds one finished hash until the consumer takes it.
module fah_out_stage
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [63:0] load_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_accession_hash
);

  logic        valid_r, valid_nxt;
  logic [63:0] hash_r;

  assign valid_nxt          = load || (valid_r && !out_ready);
  assign out_valid          = valid_r;
  assign out_accession_hash = hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hash_r <= load_hash;
    end
  end

endmodule

### rtl/core/fasta_accession_hasher.sv
// Top level of the FASTA accession hasher: input register, parser, result register.
//
//   channel  direction  payload                          handshake
//   in_      input      in_text_byte[7:0], in_end_of_data in_valid / in_ready
//   out_     output     out_accession_hash[63:0]         out_valid / out_ready
//
// One word per cycle sustained unless an out_ready stall holds a hash; a hash
// shows on out_ after the word that ends its token is accepted: the word is
// registered in the input register, then the result register loads the hash.
// The xor and constant multiply by the FNV prime are combinational logic feeding
// the running hash register, which sets the clock.
// Reset puts the parser at line start with the hash at the offset basis.
// An out_ready stall holds the word in the input register and the hash in
// the result register; in_ready drops only while both are held.
module fasta_accession_hasher
  import fah_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_accession_hash
);

  fah_word_t   in_word;
  fah_word_t   word;
  fah_result_t result;
  logic        word_valid;
  logic        advance;

  assign in_word.text_byte   = in_text_byte;
  assign in_word.end_of_data = in_end_of_data;

  // advance the held word once the result register can take whatever it makes
  assign advance = word_valid && (!out_valid || out_ready);

  fah_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  fah_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .word   (word),
    .result (result)
  );

  fah_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (advance && result.emit),
    .load_hash          (result.hash),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accession_hash (out_accession_hash)
  );

endmodule
